// File: src/lr_shift_reduce_driver_macros.svh
// Assertion macros for the LR shift/reduce driver.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef LR_SHIFT_REDUCE_DRIVER_MACROS_SVH
`define LR_SHIFT_REDUCE_DRIVER_MACROS_SVH
`ifndef SYNTHESIS
`define LRSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LRSR_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define LRSR_ASSERT(lbl, prop, msg)
`define LRSR_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: src/lrsr_pkg.sv
`timescale 1ns / 1ps
package lrsr_pkg;

  localparam logic [1:0] OP_LOAD_ACT  = 2'd0;
  localparam logic [1:0] OP_LOAD_RULE = 2'd1;
  localparam logic [1:0] OP_BEGIN     = 2'd2;
  localparam logic [1:0] OP_TOKEN     = 2'd3;

  localparam logic [2:0] K_NONE   = 3'd0;
  localparam logic [2:0] K_SHIFT  = 3'd1;
  localparam logic [2:0] K_REDUCE = 3'd2;
  localparam logic [2:0] K_GOTO   = 3'd3;
  localparam logic [2:0] K_ACCEPT = 3'd4;

  localparam logic [2:0] R_REDUCED  = 3'd0;
  localparam logic [2:0] R_SHIFTED  = 3'd1;
  localparam logic [2:0] R_ACCEPTED = 3'd2;
  localparam logic [2:0] R_ERROR    = 3'd3;
  localparam logic [2:0] R_ACK      = 3'd4;

  localparam logic [2:0] C_NONE      = 3'd0;
  localparam logic [2:0] C_NO_ACTION = 3'd1;
  localparam logic [2:0] C_GOTO_ACT  = 3'd2;
  localparam logic [2:0] C_NO_GOTO   = 3'd3;
  localparam logic [2:0] C_STACK     = 3'd4;
  localparam logic [2:0] C_TOO_LONG  = 3'd5;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    logic [1:0] opcode;
    logic       in_range;
    logic [7:0] st;
    logic [5:0] sym;
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] rule_idx;
    logic [3:0] rule_len;
    logic [5:0] rule_lhs;
    logic [5:0] tok;
  } lrsr_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] rule;
    logic [2:0] cause;
    logic       last;
  } lrsr_result_t;

  typedef struct packed {
    logic busy;
    logic clearing;
  } lrsr_status_t;

endpackage

// File: src/lrsr_front.sv
`timescale 1ns / 1ps
module lrsr_front import lrsr_pkg::*; #(
  parameter int STATES  = 256,
  parameter int SYMBOLS = 64,
  parameter int RULES   = 256
) (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        clearing_i,
  input  logic        q_full_i,
  output logic        push_o,
  output lrsr_cmd_t   cmd_o
);

  logic [2:0] raw_kind;

  assign s_axis_tready = !clearing_i && !q_full_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;
  assign raw_kind      = s_axis_tdata[16:14];

  always_comb begin
    cmd_o.opcode   = s_axis_tuser;
    cmd_o.st       = s_axis_tdata[7:0];
    cmd_o.sym      = s_axis_tdata[13:8];
    // Kinds beyond accept are stored as none.
    cmd_o.kind     = (raw_kind > K_ACCEPT) ? K_NONE : raw_kind;
    cmd_o.value    = s_axis_tdata[24:17];
    cmd_o.rule_idx = s_axis_tdata[32:25];
    cmd_o.rule_len = s_axis_tdata[36:33];
    cmd_o.rule_lhs = s_axis_tdata[42:37];
    cmd_o.tok      = s_axis_tdata[48:43];
    if (s_axis_tuser == OP_LOAD_RULE) begin
      cmd_o.in_range = 32'(s_axis_tdata[32:25]) < RULES;
    end else begin
      cmd_o.in_range = (32'(s_axis_tdata[7:0]) < STATES) &&
                       (32'(s_axis_tdata[13:8]) < SYMBOLS);
    end
  end

endmodule

// File: src/lrsr_fifo.sv
`timescale 1ns / 1ps
module lrsr_fifo import lrsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lrsr_cmd_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output lrsr_cmd_t data_o
);

  lrsr_cmd_t  mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = !wr_q;
    end
    if (pop_i) begin
      rd_d = !rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: src/lrsr_back.sv
`timescale 1ns / 1ps
module lrsr_back import lrsr_pkg::*; #(
  parameter int STATES         = 256,
  parameter int SYMBOLS        = 64,
  parameter int RULES          = 256,
  parameter int STACK_DEPTH    = 64,
  parameter int MAX_REDUCTIONS = 63
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  input  lrsr_cmd_t    cmd_i,
  output logic         cmd_pop_o,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output lrsr_result_t res_o,
  output lrsr_status_t status_o
);

  localparam int ACT_DEPTH = STATES * SYMBOLS;
  localparam int AW  = $clog2(ACT_DEPTH);
  localparam int RW  = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(MAX_REDUCTIONS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ALOOK = 3'd2;
  localparam logic [2:0] S_ADEC  = 3'd3;
  localparam logic [2:0] S_RULE  = 3'd4;
  localparam logic [2:0] S_STK   = 3'd5;
  localparam logic [2:0] S_GOTO  = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  function automatic logic [AW-1:0] act_addr(logic [7:0] st, logic [5:0] sym);
    act_addr = AW'(32'(st) * SYMBOLS + 32'(sym));
  endfunction

  function automatic logic act_oor(logic [7:0] st, logic [5:0] sym);
    act_oor = !((32'(st) < STATES) && (32'(sym) < SYMBOLS));
  endfunction

  logic [10:0] act_mem [ACT_DEPTH];
  logic [9:0]  rule_mem [RULES];
  logic [7:0]  stk_mem [STACK_DEPTH];

  logic [2:0]   state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  lrsr_cmd_t    cmd_q;
  logic [SPW-1:0] sp_q, sp_d;
  logic [7:0]   top_q, top_d;
  logic [1:0]   pstat_q, pstat_d;
  logic [CW-1:0] red_q, red_d;
  logic [7:0]   rule_q, rule_d;
  logic         oor_q, oor_d;
  logic         out_v_q, out_v_d;
  lrsr_result_t out_q;

  logic         act_we, act_re, rule_we, rule_re, stk_we, stk_re;
  logic [AW-1:0] act_wa, act_ra;
  logic [10:0]  act_wd, act_rd_q;
  logic [RW-1:0] rule_wa, rule_ra;
  logic [9:0]   rule_wd, rule_rd_q;
  logic [SIW-1:0] stk_wa, stk_ra;
  logic [7:0]   stk_wd, stk_rd_q;

  logic         can_emit, emit;
  lrsr_result_t res;
  logic [2:0]   a_kind;
  logic [7:0]   a_val;
  logic [3:0]   r_len;
  logic         stk_full;

  assign can_emit = !out_v_q || res_ready_i;
  assign a_kind   = oor_q ? K_NONE : act_rd_q[10:8];
  assign a_val    = act_rd_q[7:0];
  assign r_len    = rule_rd_q[9:6];
  assign stk_full = sp_q == SPW'(STACK_DEPTH);

  assign res_valid_o       = out_v_q;
  assign res_o             = out_q;
  assign status_o.busy     = state_q != S_IDLE;
  assign status_o.clearing = state_q == S_CLEAR;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    sp_d      = sp_q;
    top_d     = top_q;
    pstat_d   = pstat_q;
    red_d     = red_q;
    rule_d    = rule_q;
    oor_d     = oor_q;
    cmd_pop_o = 1'b0;
    act_we    = 1'b0;
    act_wa    = act_addr(cmd_q.st, cmd_q.sym);
    act_wd    = {cmd_q.kind, cmd_q.value};
    act_re    = 1'b0;
    act_ra    = act_addr(top_q, cmd_q.tok);
    rule_we   = 1'b0;
    rule_wa   = RW'(cmd_q.rule_idx);
    rule_wd   = {cmd_q.rule_len, cmd_q.rule_lhs};
    rule_re   = 1'b0;
    rule_ra   = RW'(a_val);
    stk_we    = 1'b0;
    stk_wa    = SIW'(sp_q);
    stk_wd    = a_val;
    stk_re    = 1'b0;
    stk_ra    = SIW'(32'(sp_q) - 32'(r_len) - 1);
    emit      = 1'b0;
    res       = '{kind: R_ACK, rule: 8'd0, cause: C_NONE, last: 1'b1};
    case (state_q)
      S_CLEAR: begin
        act_we = 1'b1;
        act_wa = clr_q;
        act_wd = '0;
        if (clr_q == AW'(ACT_DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q.opcode)
          OP_LOAD_ACT: begin
            if (can_emit) begin
              act_we  = cmd_q.in_range;
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end
          OP_LOAD_RULE: begin
            if (can_emit) begin
              rule_we = cmd_q.in_range;
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end
          OP_BEGIN: begin
            if (can_emit) begin
              stk_we  = 1'b1;
              stk_wa  = '0;
              stk_wd  = 8'd0;
              sp_d    = SPW'(1);
              top_d   = 8'd0;
              pstat_d = ST_RUN;
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: begin
            if (pstat_q != ST_RUN || sp_q == '0) begin
              if (can_emit) begin
                res.kind  = R_ERROR;
                res.cause = (pstat_q == ST_DONE && sp_q != '0) ? C_NONE : C_STACK;
                emit      = 1'b1;
                state_d   = S_IDLE;
              end
            end else begin
              red_d   = '0;
              act_re  = 1'b1;
              oor_d   = act_oor(top_q, cmd_q.tok);
              state_d = S_ADEC;
            end
          end
        endcase
      end
      S_ALOOK: begin
        act_re  = 1'b1;
        oor_d   = act_oor(top_q, cmd_q.tok);
        state_d = S_ADEC;
      end
      S_ADEC: begin
        if (a_kind == K_REDUCE && red_q < CW'(MAX_REDUCTIONS) &&
            32'(a_val) < RULES) begin
          rule_re = 1'b1;
          rule_d  = a_val;
          state_d = S_RULE;
        end else if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          res.kind = R_ERROR;
          if (a_kind == K_SHIFT) begin
            if (stk_full) begin
              res.cause = C_STACK;
              pstat_d   = ST_DONE;
            end else begin
              res.kind = R_SHIFTED;
              stk_we   = 1'b1;
              sp_d     = sp_q + SPW'(1);
              top_d    = a_val;
            end
          end else if (a_kind == K_ACCEPT) begin
            res.kind = R_ACCEPTED;
            pstat_d  = ST_DONE;
          end else begin
            pstat_d = ST_DONE;
            if (a_kind == K_GOTO) begin
              res.cause = C_GOTO_ACT;
            end else if (a_kind != K_REDUCE) begin
              res.cause = C_NO_ACTION;
            end else if (red_q >= CW'(MAX_REDUCTIONS)) begin
              res.cause = C_TOO_LONG;
            end else begin
              res.cause = C_NO_ACTION;
            end
          end
        end
      end
      S_RULE: begin
        if (32'(sp_q) <= 32'(r_len)) begin
          if (can_emit) begin
            res.kind  = R_ERROR;
            res.cause = C_STACK;
            pstat_d   = ST_DONE;
            emit      = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          sp_d    = SPW'(32'(sp_q) - 32'(r_len));
          stk_re  = 1'b1;
          state_d = S_STK;
        end
      end
      S_STK: begin
        act_re  = 1'b1;
        act_ra  = act_addr(stk_rd_q, rule_rd_q[5:0]);
        oor_d   = act_oor(stk_rd_q, rule_rd_q[5:0]);
        state_d = S_GOTO;
      end
      S_GOTO: begin
        if (can_emit) begin
          emit = 1'b1;
          if (a_kind != K_GOTO || stk_full) begin
            res.kind  = R_ERROR;
            res.cause = (a_kind != K_GOTO) ? C_NO_GOTO : C_STACK;
            pstat_d   = ST_DONE;
            state_d   = S_IDLE;
          end else begin
            res.kind = R_REDUCED;
            res.rule = rule_q;
            res.last = 1'b0;
            stk_we   = 1'b1;
            sp_d     = sp_q + SPW'(1);
            top_d    = a_val;
            red_d    = red_q + CW'(1);
            state_d  = S_ALOOK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_v_d = emit ? 1'b1 : (res_ready_i ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_mem[act_wa] <= act_wd;
    end
    if (act_re) begin
      act_rd_q <= act_mem[act_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rule_we) begin
      rule_mem[rule_wa] <= rule_wd;
    end
    if (rule_re) begin
      rule_rd_q <= rule_mem[rule_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      out_q <= res;
    end
    rule_q <= rule_d;
    oor_q  <= oor_d;
    top_q  <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      sp_q    <= '0;
      pstat_q <= ST_IDLE;
      red_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      pstat_q <= pstat_d;
      red_q   <= red_d;
      out_v_q <= out_v_d;
    end
  end

endmodule

// File: src/lr_shift_reduce_driver.sv
// Operation: the back sequencer runs one command at a time; each reduction of a token reads
// the rule, the stack and the goto entry, emits a reduced result, then looks up again.
// Up to two further commands wait in the queue meanwhile.
// Reset: asynchronous, active low; afterwards the action table is swept to kind none, one
// entry a cycle, while no item transfer is taken.
`timescale 1ns / 1ps
`include "lr_shift_reduce_driver_macros.svh"
module lr_shift_reduce_driver import lrsr_pkg::*; #(
  parameter int STATES         = 256,
  parameter int SYMBOLS        = 64,
  parameter int RULES          = 256,
  parameter int STACK_DEPTH    = 64,
  parameter int MAX_REDUCTIONS = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0 up: entry_state(8) entry_symbol(6) entry_kind(3) entry_value(8)
  // rule_index(8) rule_length(4) rule_lhs(6) token_type(6), zero fill.
  input  logic [55:0] s_axis_tdata,
  // opcode(2).
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0 up: rule_applied(8) error_cause(3), zero fill.
  output logic [15:0] m_axis_tdata,
  // result_kind(3).
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  // The front decodes each transfer into a command and drops it into a two-entry queue.
  // The back pops one command at a time and runs it against the tables and the stack.
  lrsr_cmd_t    front_cmd, q_cmd;
  logic         front_push, q_full, q_valid, q_pop;
  lrsr_result_t res;
  logic         res_valid;
  lrsr_status_t status;
  logic [5:0]   end_symbol_q;

  lrsr_front #(
    .STATES (STATES),
    .SYMBOLS(SYMBOLS),
    .RULES  (RULES)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .clearing_i   (status.clearing),
    .q_full_i     (q_full),
    .push_o       (front_push),
    .cmd_o        (front_cmd)
  );

  lrsr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_cmd)
  );

  lrsr_back #(
    .STATES        (STATES),
    .SYMBOLS       (SYMBOLS),
    .RULES         (RULES),
    .STACK_DEPTH   (STACK_DEPTH),
    .MAX_REDUCTIONS(MAX_REDUCTIONS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .res_valid_o(res_valid),
    .res_ready_i(m_axis_tready),
    .res_o      (res),
    .status_o   (status)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {5'd0, res.cause, res.rule};
  assign m_axis_tuser  = res.kind;
  assign m_axis_tlast  = res.last;

  // The end symbol is only recorded; the host sends it as an ordinary token. A write
  // transfer is taken only when nothing is queued, running or waiting at the output.
  assign cfg_ready_o = !status.busy && !q_valid && !res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_symbol_q <= 6'd63;
    end else if (cfg_valid_i && cfg_ready_o) begin
      end_symbol_q <= cfg_data_i;
    end
  end

  `LRSR_ASSERT_NEVER(a_no_take_while_clearing, s_axis_tvalid && s_axis_tready && status.clearing, "item taken during table sweep")
  `LRSR_ASSERT(a_cfg_stable_when_busy, status.busy |=> $stable(end_symbol_q), "end symbol changed while busy")
  `LRSR_ASSERT_NEVER(a_no_pop_when_empty, q_pop && !q_valid, "command popped from empty queue")

endmodule
